>>> sv/bba_pkg.sv
`default_nettype none
package bba_pkg;

    localparam int LEVEL_COUNT = 14;
    localparam int REGION_LOG2 = 20;

    localparam int LVL_W  = $clog2(LEVEL_COUNT + 1);
    localparam int SH_W   = $clog2(REGION_LOG2 + 1);
    localparam int ADDR_W = REGION_LOG2 + 1;
    localparam int WIDE_W = 33;

    localparam logic [WIDE_W-1:0] REGION_BYTES = WIDE_W'(1) << REGION_LOG2;

    typedef logic [LEVEL_COUNT-1:0] node_t;
    typedef logic [LEVEL_COUNT-1:0] mask_t;
    typedef logic [LVL_W-1:0]       lvl_t;
    typedef logic [SH_W-1:0]        shift_t;

    localparam logic [1:0] ST_ABSENT = 2'd0;
    localparam logic [1:0] ST_FREE   = 2'd1;
    localparam logic [1:0] ST_ALLOC  = 2'd2;
    localparam logic [1:0] ST_SPLIT  = 2'd3;

    localparam logic [1:0] RES_DONE      = 2'd0;
    localparam logic [1:0] RES_TOO_LARGE = 2'd1;
    localparam logic [1:0] RES_NO_SPACE  = 2'd2;
    localparam logic [1:0] RES_NOT_FOUND = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;

    typedef struct packed {
        logic [1:0] status;
        mask_t      mask;
    } entry_t;

    typedef struct packed {
        logic   wr_en;
        node_t  wr_addr;
        entry_t wr_data;
        logic   rd_en;
        node_t  rd_addr;
    } mem_req_t;

    function automatic mask_t level_bit(input lvl_t l);
        return mask_t'(1) << l;
    endfunction

    function automatic shift_t level_shift(input lvl_t l);
        return shift_t'(REGION_LOG2) - shift_t'(l);
    endfunction

endpackage
`default_nettype wire

>>> sv/bba_node_mem.sv
`default_nettype none
module bba_node_mem
    import bba_pkg::*;
(
    input  wire logic     aclk,
    input  wire mem_req_t req,
    output entry_t        rd_data
);

    entry_t mem [2**LEVEL_COUNT];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> sv/buddy_block_allocator_core.sv
// allocate walks down to the level served and back up to the root; free walks down to the
// freed block and back up, merging free buddies; both make one node memory
// access per tree level on the way down and one per level on the way up
// rejects: too large or out of range at acceptance, no space after the root read, free not found on the walk down
// one item at a time; s_ready is high only while idle
// reset: synchronous active-low; after reset the init state writes the root entry as free
`default_nettype none
module buddy_block_allocator_core
    import bba_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [20:0] s_request_size,
    input  wire logic [20:0] s_block_offset,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [19:0]      m_granted_offset,
    output logic [1:0]       m_status
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_AROOT  = 4'd2;
    localparam logic [3:0] S_ADESC  = 4'd3;
    localparam logic [3:0] S_SPLIT  = 4'd4;
    localparam logic [3:0] S_UP     = 4'd5;
    localparam logic [3:0] S_FWALK  = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;

    logic [3:0]        state_reg, state_next;
    node_t             node_reg, node_next;
    lvl_t              lvl_reg, lvl_next;
    lvl_t              op_reg, op_next;
    lvl_t              tgt_reg, tgt_next;
    mask_t             cur_mask_reg, cur_mask_next;
    logic              merging_reg, merging_next;
    logic [20:0]       off_reg, off_next;
    logic [19:0]       res_off_reg, res_off_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              m_valid_reg, m_valid_next;
    logic [19:0]       m_off_reg, m_off_next;
    logic [1:0]        m_status_reg, m_status_next;

    mem_req_t          req;
    entry_t            rd_data;

    logic [WIDE_W-1:0] req_wide;
    logic [WIDE_W-1:0] off_wide;
    lvl_t              op_calc;
    lvl_t              tgt_calc;
    logic              tgt_found;
    logic [ADDR_W-1:0] off_addr;
    logic [63:0]       grant_full;
    node_t             par;
    entry_t            up_entry;

    bba_node_mem u_mem (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign req_wide = WIDE_W'(s_request_size);
    assign off_wide = WIDE_W'(s_block_offset);
    assign off_addr = ADDR_W'(off_reg);
    assign par      = node_reg >> 1;

    always_comb begin
        op_calc = '0;
        for (int k = 0; k < LEVEL_COUNT; k++) begin
            if (req_wide <= (WIDE_W'(1) << level_shift(lvl_t'(k)))) begin
                op_calc = lvl_t'(k);
            end
        end
    end

    always_comb begin
        tgt_calc  = '0;
        tgt_found = 1'b0;
        for (int k = 0; k < LEVEL_COUNT; k++) begin
            if (lvl_t'(k) <= op_reg && rd_data.mask[k]) begin
                tgt_calc  = lvl_t'(k);
                tgt_found = 1'b1;
            end
        end
    end

    assign grant_full = 64'(node_reg & ~(node_t'(1) << lvl_reg)) << level_shift(lvl_reg);

    always_comb begin
        if (merging_reg && rd_data.status == ST_FREE) begin
            up_entry = '{status: ST_FREE, mask: level_bit(lvl_reg - lvl_t'(1))};
        end else begin
            up_entry = '{status: ST_SPLIT, mask: cur_mask_reg | rd_data.mask};
        end
    end

    always_comb begin
        state_next      = state_reg;
        node_next       = node_reg;
        lvl_next        = lvl_reg;
        op_next         = op_reg;
        tgt_next        = tgt_reg;
        cur_mask_next   = cur_mask_reg;
        merging_next    = merging_reg;
        off_next        = off_reg;
        res_off_next    = res_off_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_off_next      = m_off_reg;
        m_status_next   = m_status_reg;
        req             = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                req.wr_en   = 1'b1;
                req.wr_addr = node_t'(1);
                req.wr_data = '{status: ST_FREE, mask: level_bit('0)};
                state_next  = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    node_next    = node_t'(1);
                    lvl_next     = '0;
                    op_next      = op_calc;
                    off_next     = s_block_offset;
                    res_off_next = '0;
                    if (s_kind == KIND_ALLOC) begin
                        if (req_wide > REGION_BYTES) begin
                            res_status_next = RES_TOO_LARGE;
                            state_next      = S_OUT;
                        end else begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = node_t'(1);
                            state_next  = S_AROOT;
                        end
                    end else begin
                        if (off_wide >= REGION_BYTES) begin
                            res_status_next = RES_NOT_FOUND;
                            state_next      = S_OUT;
                        end else begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = node_t'(1);
                            state_next  = S_FWALK;
                        end
                    end
                end
            end
            S_AROOT: begin
                tgt_next = tgt_calc;
                if (!tgt_found) begin
                    res_status_next = RES_NO_SPACE;
                    state_next      = S_OUT;
                end else if (tgt_calc == '0) begin
                    state_next = S_SPLIT;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = node_t'(2);
                    state_next  = S_ADESC;
                end
            end
            S_ADESC: begin
                node_next = {node_reg[LEVEL_COUNT-2:0], ~rd_data.mask[tgt_reg]};
                lvl_next  = lvl_reg + lvl_t'(1);
                if (lvl_reg + lvl_t'(1) == tgt_reg) begin
                    state_next = S_SPLIT;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = {node_reg[LEVEL_COUNT-3:0], ~rd_data.mask[tgt_reg], 1'b0};
                end
            end
            S_SPLIT: begin
                req.wr_en = 1'b1;
                if (lvl_reg < op_reg) begin
                    req.wr_addr = {node_reg[LEVEL_COUNT-2:0], 1'b1};
                    req.wr_data = '{status: ST_FREE, mask: level_bit(lvl_reg + lvl_t'(1))};
                    node_next   = {node_reg[LEVEL_COUNT-2:0], 1'b0};
                    lvl_next    = lvl_reg + lvl_t'(1);
                end else begin
                    req.wr_addr     = node_reg;
                    req.wr_data     = '{status: ST_ALLOC, mask: '0};
                    cur_mask_next   = '0;
                    merging_next    = 1'b0;
                    res_off_next    = grant_full[19:0];
                    res_status_next = RES_DONE;
                    if (node_reg == node_t'(1)) begin
                        state_next = S_OUT;
                    end else begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = node_reg ^ node_t'(1);
                        state_next  = S_UP;
                    end
                end
            end
            S_UP: begin
                req.wr_en     = 1'b1;
                req.wr_addr   = par;
                req.wr_data   = up_entry;
                cur_mask_next = up_entry.mask;
                merging_next  = merging_reg && rd_data.status == ST_FREE;
                node_next     = par;
                lvl_next      = lvl_reg - lvl_t'(1);
                if (par == node_t'(1)) begin
                    state_next = S_OUT;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = par ^ node_t'(1);
                end
            end
            S_FWALK: begin
                if (rd_data.status == ST_SPLIT && LVL_W'(lvl_reg + lvl_t'(1)) <
                        LVL_W'(LEVEL_COUNT)) begin
                    node_next   = {node_reg[LEVEL_COUNT-2:0],
                                   off_addr[level_shift(lvl_reg + lvl_t'(1))]};
                    lvl_next    = lvl_reg + lvl_t'(1);
                    req.rd_en   = 1'b1;
                    req.rd_addr = {node_reg[LEVEL_COUNT-2:0],
                                   off_addr[level_shift(lvl_reg + lvl_t'(1))]};
                end else if ((off_addr & ((ADDR_W'(1) << level_shift(lvl_reg)) -
                        ADDR_W'(1))) != '0 || rd_data.status == ST_ABSENT ||
                        rd_data.status == ST_SPLIT) begin
                    res_status_next = RES_NOT_FOUND;
                    state_next      = S_OUT;
                end else begin
                    req.wr_en       = 1'b1;
                    req.wr_addr     = node_reg;
                    req.wr_data     = '{status: ST_FREE, mask: level_bit(lvl_reg)};
                    cur_mask_next   = level_bit(lvl_reg);
                    merging_next    = 1'b1;
                    res_status_next = RES_DONE;
                    if (node_reg == node_t'(1)) begin
                        state_next = S_OUT;
                    end else begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = node_reg ^ node_t'(1);
                        state_next  = S_UP;
                    end
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_off_next    = res_off_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        node_reg       <= node_next;
        lvl_reg        <= lvl_next;
        op_reg         <= op_next;
        tgt_reg        <= tgt_next;
        cur_mask_reg   <= cur_mask_next;
        merging_reg    <= merging_next;
        off_reg        <= off_next;
        res_off_reg    <= res_off_next;
        res_status_reg <= res_status_next;
        m_off_reg      <= m_off_next;
        m_status_reg   <= m_status_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_granted_offset = m_off_reg;
    assign m_status         = m_status_reg;

endmodule
`default_nettype wire

>>> sv/bba_checker.sv
`default_nettype none
module bba_checker
    import bba_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_kind,
    input wire logic [20:0] s_request_size,
    input wire logic [20:0] s_block_offset,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [19:0] m_granted_offset,
    input wire logic [1:0]  m_status
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_granted_offset))
        else $error("result item changed while stalled");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != RES_DONE |-> m_granted_offset == '0)
        else $error("failed item carries an offset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a second item while busy");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("outputs active after reset");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);
`default_nettype wire
